[rtl/core/ctb_pkg.sv]
// Package for the cursor text buffer: command and status codes, controller/datapath structs.
// Depends on nothing; ctb_ctrl, ctb_datapath and cursor_text_buffer use it by scoped names.
package ctb_pkg;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_LEFT   = 3'd1;
    localparam logic [2:0] OP_RIGHT  = 3'd2;
    localparam logic [2:0] OP_BACK   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EDGE  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic load;
        logic commit;
    } ctb_cmd_t;

    typedef struct packed {
        logic out_hold;
    } ctb_sts_t;

endpackage

[rtl/core/ctb_if.sv]
// Valid/ready channel interfaces for the cursor text buffer: command in, response out.
// Depends on nothing; used by the top level ports.
interface ctb_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] char_in;
    logic [9:0] read_index;

    modport source (output valid, output opcode, output char_in, output read_index,
                    input ready);
    modport sink   (input valid, input opcode, input char_in, input read_index,
                    output ready);
endinterface

interface ctb_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  char_out;
    logic [10:0] text_length;
    logic [10:0] cursor_pos;

    modport source (output valid, output status, output char_out, output text_length,
                    output cursor_pos, input ready);
    modport sink   (input valid, input status, input char_out, input text_length,
                    input cursor_pos, output ready);
endinterface

[rtl/core/ctb_stack_ram.sv]
// Single-port-write, single-port-read stack memory with registered read data.
// Depends on nothing; instanced twice by ctb_datapath.
module ctb_stack_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/ctb_ctrl.sv]
// Controller of the cursor text buffer: two-state machine that sequences load and commit.
// Depends on ctb_pkg.
module ctb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ctb_pkg::ctb_sts_t sts,
    output ctb_pkg::ctb_cmd_t cmd_ctl
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FIN  = 2'b10
    } ctb_state_t;

    ctb_state_t state_reg;
    ctb_state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd_ctl.load   = 1'b0;
        cmd_ctl.commit = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_ctl.load = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!sts.out_hold)
                begin
                    cmd_ctl.commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/ctb_datapath.sv]
// Datapath of the cursor text buffer: both stacks, their counts, command latch, result register.
// Depends on ctb_pkg and ctb_stack_ram; driven by ctb_ctrl.
module ctb_datapath #(
    parameter int CAPACITY = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ctb_pkg::ctb_cmd_t cmd_ctl,
    output ctb_pkg::ctb_sts_t sts,
    input  logic [2:0]        opcode,
    input  logic [7:0]        char_in,
    input  logic [9:0]        read_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [7:0]        char_out,
    output logic [10:0]       text_length,
    output logic [10:0]       cursor_pos
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = (CW + 1 > 10) ? CW + 1 : 10;

    logic [CW-1:0] left_count_reg,  left_count_next;
    logic [CW-1:0] right_count_reg, right_count_next;
    logic [2:0]    op_reg;
    logic [7:0]    char_reg;
    logic [1:0]    status_pend_reg, status_pend_next;
    logic          read_sel_reg,    read_sel_next;
    logic          out_valid_reg,   out_valid_next;
    logic [1:0]    status_reg;
    logic [7:0]    char_out_reg,    char_out_next;
    logic [10:0]   text_length_reg;
    logic [10:0]   cursor_pos_reg;

    logic [XW-1:0] lc_x, rc_x, total_x, idx_x, cap_x, rpos_x, lc_m1_x, rc_m1_x;
    logic [AW-1:0] left_raddr, right_raddr;
    logic [AW-1:0] left_waddr, right_waddr;
    logic [7:0]    left_wdata, left_rdata, right_rdata;
    logic          left_we, right_we;
    logic          do_apply;

    assign lc_x    = XW'(left_count_reg);
    assign rc_x    = XW'(right_count_reg);
    assign total_x = lc_x + rc_x;
    assign idx_x   = XW'(read_index);
    assign cap_x   = XW'(CAPACITY);
    assign lc_m1_x = lc_x - XW'(1);
    assign rc_m1_x = rc_x - XW'(1);
    assign rpos_x  = total_x - XW'(1) - idx_x;

    always_comb
    begin
        status_pend_next = ctb_pkg::ST_DONE;
        case (opcode)
            ctb_pkg::OP_INSERT:
                if (total_x >= cap_x) status_pend_next = ctb_pkg::ST_FULL;
            ctb_pkg::OP_LEFT:
                if (lc_x == '0 || rc_x >= cap_x) status_pend_next = ctb_pkg::ST_EDGE;
            ctb_pkg::OP_RIGHT:
                if (rc_x == '0 || lc_x >= cap_x) status_pend_next = ctb_pkg::ST_EDGE;
            ctb_pkg::OP_BACK:
                if (lc_x == '0) status_pend_next = ctb_pkg::ST_EDGE;
            ctb_pkg::OP_READ:
                if (idx_x >= total_x) status_pend_next = ctb_pkg::ST_RANGE;
            default:
                status_pend_next = ctb_pkg::ST_DONE;
        endcase
    end

    assign read_sel_next = (idx_x >= lc_x);
    assign left_raddr    = (opcode == ctb_pkg::OP_READ) ? idx_x[AW-1:0]  : lc_m1_x[AW-1:0];
    assign right_raddr   = (opcode == ctb_pkg::OP_READ) ? rpos_x[AW-1:0] : rc_m1_x[AW-1:0];

    assign do_apply = cmd_ctl.commit && (status_pend_reg == ctb_pkg::ST_DONE);

    always_comb
    begin
        left_count_next  = left_count_reg;
        right_count_next = right_count_reg;
        left_we          = 1'b0;
        right_we         = 1'b0;
        left_wdata       = char_reg;
        left_waddr       = lc_x[AW-1:0];
        right_waddr      = rc_x[AW-1:0];
        char_out_next    = 8'd0;
        if (do_apply)
        begin
            case (op_reg)
                ctb_pkg::OP_INSERT:
                begin
                    left_we         = 1'b1;
                    left_count_next = left_count_reg + CW'(1);
                end
                ctb_pkg::OP_LEFT:
                begin
                    right_we         = 1'b1;
                    left_count_next  = left_count_reg - CW'(1);
                    right_count_next = right_count_reg + CW'(1);
                end
                ctb_pkg::OP_RIGHT:
                begin
                    left_we          = 1'b1;
                    left_wdata       = right_rdata;
                    left_count_next  = left_count_reg + CW'(1);
                    right_count_next = right_count_reg - CW'(1);
                end
                ctb_pkg::OP_BACK:
                begin
                    left_count_next = left_count_reg - CW'(1);
                end
                ctb_pkg::OP_READ:
                begin
                    char_out_next = read_sel_reg ? right_rdata : left_rdata;
                end
                default:
                begin
                    char_out_next = 8'd0;
                end
            endcase
        end
    end

    ctb_stack_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_left_ram (
        .clk   (clk),
        .we    (left_we),
        .waddr (left_waddr),
        .wdata (left_wdata),
        .re    (cmd_ctl.load),
        .raddr (left_raddr),
        .rdata (left_rdata)
    );

    ctb_stack_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_right_ram (
        .clk   (clk),
        .we    (right_we),
        .waddr (right_waddr),
        .wdata (left_rdata),
        .re    (cmd_ctl.load),
        .raddr (right_raddr),
        .rdata (right_rdata)
    );

    assign out_valid_next = cmd_ctl.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_count_reg  <= '0;
            right_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            left_count_reg  <= left_count_next;
            right_count_reg <= right_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ctl.load)
        begin
            op_reg          <= opcode;
            char_reg        <= char_in;
            status_pend_reg <= status_pend_next;
            read_sel_reg    <= read_sel_next;
        end
        if (cmd_ctl.commit)
        begin
            status_reg      <= status_pend_reg;
            char_out_reg    <= char_out_next;
            text_length_reg <= 11'(XW'(left_count_next) + XW'(right_count_next));
            cursor_pos_reg  <= 11'(left_count_next);
        end
    end

    assign sts.out_hold = out_valid_reg && !out_ready;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign char_out     = char_out_reg;
    assign text_length  = text_length_reg;
    assign cursor_pos   = cursor_pos_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (XW'(left_count_reg) + XW'(right_count_reg)) <= XW'(CAPACITY))
        else $error("stack counts exceed capacity");

    a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ctl.commit |=> $stable(left_count_reg) && $stable(right_count_reg))
        else $error("counts changed outside commit");

    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ctl.commit && status_pend_reg != ctb_pkg::ST_DONE
        |=> $stable(left_count_reg) && $stable(right_count_reg))
        else $error("rejected command changed counts");

    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ctl.commit |=> out_valid_reg)
        else $error("committed result not presented");

endmodule

[rtl/core/cursor_text_buffer.sv]
// Cursor text buffer: a one-line gap buffer editor with insert, move, backspace and read commands.
// Depends on ctb_pkg, ctb_if, ctb_ctrl, ctb_datapath and ctb_stack_ram.
//
// Each command is accepted in S_IDLE, where the top of a stack (or the indexed character) is
// read from its memory, and committed in S_FIN while no earlier response is held: unless it is
// rejected, an insert writes the left stack, a move writes the other stack and the counts
// advance, and the response is registered. Both stacks are single-write, single-read memories.
// A new command is accepted the cycle after the commit, while the previous response may still wait
// in the output register; a stalled response delays only the commit of the following command.
// Stacks need no clearing after reset; only entries below each count are ever used.
module cursor_text_buffer #(
    parameter int CAPACITY = 1024
) (
    input  logic     clk,
    input  logic     rst_n,
    ctb_cmd_if.sink  cmd,
    ctb_rsp_if.source rsp
);

    ctb_pkg::ctb_cmd_t cmd_ctl;
    ctb_pkg::ctb_sts_t sts;

    ctb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .sts      (sts),
        .cmd_ctl  (cmd_ctl)
    );

    ctb_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_ctl     (cmd_ctl),
        .sts         (sts),
        .opcode      (cmd.opcode),
        .char_in     (cmd.char_in),
        .read_index  (cmd.read_index),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .status      (rsp.status),
        .char_out    (rsp.char_out),
        .text_length (rsp.text_length),
        .cursor_pos  (rsp.cursor_pos)
    );

endmodule

[tb/cursor_text_buffer_tb.sv]
// Self-checking testbench for cursor_text_buffer: drives edit commands, predicts each response.
// Depends on ctb_pkg, the ctb_cmd_if/ctb_rsp_if channel interfaces and the cursor_text_buffer RTL.
module cursor_text_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 1024;
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD = 200;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  char_out;
        logic [10:0] text_length;
        logic [10:0] cursor_pos;
    } reply_t;

    class line_tracker;
        logic [7:0] before_cursor[CAPACITY];
        logic [7:0] after_cursor[CAPACITY];
        int left_len;
        int right_len;
        reply_t pending_replies[$];
        int errors;
        int commands;
        int replies;
        int full_hits;
        int edge_hits;
        int range_hits;

        function new();
            left_len = 0;
            right_len = 0;
            errors = 0;
            commands = 0;
            replies = 0;
            full_hits = 0;
            edge_hits = 0;
            range_hits = 0;
        endfunction

        function int text_len();
            return left_len + right_len;
        endfunction

        function void note_command(logic [2:0] op, logic [7:0] ch, logic [9:0] idx);
            reply_t r;
            int total;
            r.status = ctb_pkg::ST_DONE;
            r.char_out = 8'h00;
            total = left_len + right_len;
            commands++;
            case (op)
                ctb_pkg::OP_INSERT:
                    if (total >= CAPACITY)
                    begin
                        r.status = ctb_pkg::ST_FULL;
                    end
                    else
                    begin
                        before_cursor[left_len] = ch;
                        left_len++;
                    end
                ctb_pkg::OP_LEFT:
                    if (left_len == 0)
                    begin
                        r.status = ctb_pkg::ST_EDGE;
                    end
                    else
                    begin
                        left_len--;
                        after_cursor[right_len] = before_cursor[left_len];
                        right_len++;
                    end
                ctb_pkg::OP_RIGHT:
                    if (right_len == 0)
                    begin
                        r.status = ctb_pkg::ST_EDGE;
                    end
                    else
                    begin
                        right_len--;
                        before_cursor[left_len] = after_cursor[right_len];
                        left_len++;
                    end
                ctb_pkg::OP_BACK:
                    if (left_len == 0)
                    begin
                        r.status = ctb_pkg::ST_EDGE;
                    end
                    else
                    begin
                        left_len--;
                    end
                ctb_pkg::OP_READ:
                    if (int'(idx) >= total)
                    begin
                        r.status = ctb_pkg::ST_RANGE;
                    end
                    else if (int'(idx) < left_len)
                    begin
                        r.char_out = before_cursor[idx];
                    end
                    else
                    begin
                        r.char_out = after_cursor[right_len - 1 - (int'(idx) - left_len)];
                    end
                default: ;
            endcase
            case (r.status)
                ctb_pkg::ST_FULL:  full_hits++;
                ctb_pkg::ST_EDGE:  edge_hits++;
                ctb_pkg::ST_RANGE: range_hits++;
                default: ;
            endcase
            r.text_length = 11'(left_len + right_len);
            r.cursor_pos = 11'(left_len);
            pending_replies.push_back(r);
        endfunction

        function void check_response(reply_t got);
            reply_t want;
            replies++;
            if (pending_replies.size() == 0)
            begin
                $error("response with nothing pending: status=%0d char_out=%0h %s",
                       got.status, got.char_out,
                       $sformatf("length=%0d cursor=%0d", got.text_length, got.cursor_pos));
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.char_out !== want.char_out)
            begin
                $error("char_out: expected %0h, got %0h", want.char_out, got.char_out);
                errors++;
            end
            if (got.text_length !== want.text_length)
            begin
                $error("text_length: expected %0d, got %0d", want.text_length, got.text_length);
                errors++;
            end
            if (got.cursor_pos !== want.cursor_pos)
            begin
                $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, got.cursor_pos);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ctb_cmd_if cmd_ch();
    ctb_rsp_if rsp_ch();

    line_tracker sb;
    bit tx_burst;
    int cmds_sent;

    cursor_text_buffer #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .rsp  (rsp_ch)
    );

    always #5 clk = ~clk;

    task automatic send_cmd(input logic [2:0] op, input logic [7:0] ch, input logic [9:0] idx);
        int gap;
        if (cmds_sent % 32 == 0)
            tx_burst = ($urandom_range(0, 3) == 0);
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= op;
        cmd_ch.char_in    <= ch;
        cmd_ch.read_index <= idx;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        sb.note_command(op, ch, idx);
        cmds_sent++;
    endtask

    task automatic random_cmd(input int w_ins, input int w_left, input int w_right,
                              input int w_back, input int w_read);
        int pick;
        int total;
        logic [2:0] op;
        logic [9:0] idx;
        pick = $urandom_range(0, 99);
        total = sb.text_len();
        if (pick < w_ins)
            op = ctb_pkg::OP_INSERT;
        else if (pick < w_ins + w_left)
            op = ctb_pkg::OP_LEFT;
        else if (pick < w_ins + w_left + w_right)
            op = ctb_pkg::OP_RIGHT;
        else if (pick < w_ins + w_left + w_right + w_back)
            op = ctb_pkg::OP_BACK;
        else if (pick < w_ins + w_left + w_right + w_back + w_read)
            op = ctb_pkg::OP_READ;
        else
            op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
        if (total > 0 && $urandom_range(0, 4) != 0)
            idx = 10'($urandom_range(0, total - 1));
        else
            idx = 10'($urandom_range(0, 1023));
        send_cmd(op, 8'($urandom_range(0, 255)), idx);
    endtask

    task automatic wait_idle();
        while (sb.pending_replies.size() != 0) @(posedge clk);
    endtask

    task automatic run_directed();
        send_cmd(ctb_pkg::OP_READ, 8'h00, 10'd0);
        send_cmd(ctb_pkg::OP_READ, 8'hFF, 10'd1023);
        send_cmd(ctb_pkg::OP_LEFT, 8'h00, 10'd0);
        send_cmd(ctb_pkg::OP_BACK, 8'h00, 10'd0);
        send_cmd(ctb_pkg::OP_RIGHT, 8'h00, 10'd0);
        send_cmd(ctb_pkg::OP_INSERT, 8'h00, 10'd0);
        send_cmd(ctb_pkg::OP_INSERT, 8'hFF, 10'd1023);
        send_cmd(ctb_pkg::OP_INSERT, 8'h5A, 10'd0);
        send_cmd(ctb_pkg::OP_INSERT, 8'hA5, 10'd0);
        send_cmd(ctb_pkg::OP_RIGHT, 8'h00, 10'd0);
        send_cmd(ctb_pkg::OP_LEFT, 8'h00, 10'd0);
        send_cmd(ctb_pkg::OP_LEFT, 8'h00, 10'd0);
        send_cmd(ctb_pkg::OP_READ, 8'h00, 10'd0);
        send_cmd(ctb_pkg::OP_READ, 8'h00, 10'd3);
        send_cmd(ctb_pkg::OP_READ, 8'h00, 10'd2);
        send_cmd(ctb_pkg::OP_READ, 8'h00, 10'd4);
        send_cmd(ctb_pkg::OP_RIGHT, 8'h00, 10'd0);
        send_cmd(ctb_pkg::OP_BACK, 8'hFF, 10'd1023);
        send_cmd(ctb_pkg::OP_INSERT, 8'h3C, 10'd0);
        send_cmd(OP_SPARE_5, 8'hFF, 10'd1);
        send_cmd(OP_SPARE_6, 8'h81, 10'd1023);
        send_cmd(OP_SPARE_7, 8'h7E, 10'd2);
        send_cmd(ctb_pkg::OP_READ, 8'h00, 10'd1);
    endtask

    initial
    begin
        sb = new();
        cmds_sent = 0;
        tx_burst = 1'b0;
        rst_n <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.opcode     <= ctb_pkg::OP_INSERT;
        cmd_ch.char_in    <= 8'h00;
        cmd_ch.read_index <= 10'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        repeat (100) random_cmd(40, 15, 15, 12, 15);
        cmd_ch.valid <= 1'b0;
        wait_idle();
        @(posedge clk);
        while (sb.text_len() < CAPACITY) random_cmd(82, 5, 5, 2, 5);
        repeat (40) random_cmd(40, 20, 20, 0, 20);
        repeat (60) random_cmd(10, 15, 15, 45, 15);
        cmd_ch.valid <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d commands, %0d responses checked", sb.commands, sb.replies);
        $display("summary: %0d full inserts, %0d edge hits, %0d out-of-range reads",
                 sb.full_hits, sb.edge_hits, sb.range_hits);
        if (sb.errors == 0)
            $display("cursor_text_buffer_tb: clean");
        else
            $display("cursor_text_buffer_tb: errors");
        $finish;
    end

    initial
    begin
        int gap;
        int seen;
        bit rx_burst;
        reply_t got;
        seen = 0;
        rx_burst = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (seen % 32 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            gap = rx_burst ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
            got.status      = rsp_ch.status;
            got.char_out    = rsp_ch.char_out;
            got.text_length = rsp_ch.text_length;
            got.cursor_pos  = rsp_ch.cursor_pos;
            sb.check_response(got);
            seen++;
            if (seen == 300 || seen == 900)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("cursor_text_buffer_tb: errors");
        $finish;
    end

endmodule
